### rtl/core/mau_pkg.sv
`timescale 1ns / 1ps
package mau_pkg;
   localparam int DATA_WIDTH = 64;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_POW = 3'd3,
      MODE_INV = 3'd4,
      MODE_DIV = 3'd5,
      MODE_RES6 = 3'd6,
      MODE_RES7 = 3'd7
   } mode_type;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_NOINV = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_MUL_RUN,
      ST_POW_CHECK,
      ST_POW_SQR,
      ST_INV_CHECK,
      ST_INV_DIV,
      ST_INV_MUL,
      ST_INV_SUB,
      ST_INV_DONE,
      ST_DIV_MUL,
      ST_OUTPUT
   } state_type;

   // Request to the shared shift-add-reduce unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;
endpackage

### rtl/core/mau_serial_unit.sv
`timescale 1ns / 1ps
// Shared bit-serial unit: a modular multiply by double-and-add, or a
// restoring division giving quotient and remainder, one bit per cycle.
module mau_serial_unit #(
   parameter int WIDTH = mau_pkg::DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mau_pkg::unit_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      x,
   input  logic [WIDTH-1:0]      y,
   input  logic [WIDTH-1:0]      m,
   output mau_pkg::unit_stat_type stat,
   output logic [WIDTH-1:0]      acc,
   output logic [WIDTH-1:0]      quot
);
   import mau_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in, div_ff, div_in;
   logic [WIDTH-1:0] acc_ff, acc_in, y_ff, y_in, x_ff, m_ff;
   logic [WIDTH:0]   dbl, sum, dbl_red;
   logic [WIDTH:0]   sub_dbl, sub_sum;

   // One step: double (or shift in a dividend bit), reduce; maybe add x.
   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in = div_ff;
      acc_in = acc_ff;
      y_in = y_ff;
      dbl = {acc_ff, (div_ff ? y_ff[WIDTH-1] : 1'b0)};
      sub_dbl = dbl - {1'b0, m_ff};
      dbl_red = sub_dbl[WIDTH] ? dbl : sub_dbl;
      sum = dbl_red + {1'b0, x_ff};
      sub_sum = sum - {1'b0, m_ff};
      if (ctrl.start) begin
         busy_in = 1'b1;
         div_in = ctrl.is_div;
         acc_in = '0;
         y_in = y;
         cnt_in = CW'(WIDTH);
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = dbl_red[WIDTH-1:0];
            y_in = {y_ff[WIDTH-2:0], ~sub_dbl[WIDTH]};
         end else begin
            if (y_ff[WIDTH-1])
               acc_in = sub_sum[WIDTH] ? sum[WIDTH-1:0] : sub_sum[WIDTH-1:0];
            else
               acc_in = dbl_red[WIDTH-1:0];
            y_in = {y_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         div_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         div_ff <= div_in;
      end
      acc_ff <= acc_in;
      y_ff <= y_in;
      if (ctrl.start) begin
         x_ff <= x;
         m_ff <= m;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign acc = acc_ff;
   assign quot = y_ff;
endmodule

### rtl/core/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// Modular arithmetic unit. Each request transaction carries a mode, two
// operands and a modulus, and yields one response transaction with the
// reduced result and a status. The block handles one transaction at a
// time and is not ready while it works. All heavy work runs on one
// bit-serial unit. Zero modulus, zero divisor, modulus one and the
// unused modes go straight to the response. Every other mode first
// reduces both operands on the unit; add and subtract then finish at
// once, and a multiply adds one pass on the unit. A power adds one pass
// for each multiply or square, of which there are at most 2*WIDTH-1.
// Inverse and divide add a division and a multiply for each Euclid
// step (up to about 93 steps at 64 bits), and divide adds one closing
// multiply.
module modular_arithmetic_unit #(
   parameter int WIDTH = mau_pkg::DATA_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], operand_a[66:3], operand_b[130:67], modulus[194:131], zero pad
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result[63:0], status[65:64], zero pad
   output logic [71:0]  rsp_tdata
);
   import mau_pkg::*;

   state_type        state_ff, state_in;
   mode_type         mode_ff;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in, m_ff, e_ff, e_in;
   logic [WIDTH-1:0] acc_ff, acc_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH-1:0] t0_ff, t0_in, t1_ff, t1_in, q_ff, q_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic             rv_ff, rv_in, pow_sq_ff, pow_sq_in;
   logic [WIDTH-1:0] ux, uy, uacc, uquot, in_a, in_b, in_m;
   logic [WIDTH-1:0] mod_sel;
   logic [WIDTH:0]   sadd, ssub;
   unit_ctrl_type    uctrl;
   unit_stat_type    ustat;
   mode_type         in_mode;

   assign in_mode = mode_type'(req_tdata[2:0]);
   assign in_a = req_tdata[3 +: WIDTH];
   assign in_b = req_tdata[67 +: WIDTH];
   assign in_m = req_tdata[131 +: WIDTH];

   // The first reduction starts before the modulus is registered, and the
   // divide step of Euclid needs the divisor in place of the modulus.
   assign mod_sel = (state_ff == ST_IDLE) ? in_m :
                    (state_ff == ST_INV_CHECK) ? r1_ff : m_ff;

   mau_serial_unit #(.WIDTH(WIDTH)) u_unit (
      .clock(clock), .reset(reset), .ctrl(uctrl), .x(ux), .y(uy), .m(mod_sel),
      .stat(ustat), .acc(uacc), .quot(uquot)
   );

   assign sadd = {1'b0, a_ff} + {1'b0, b_ff};
   assign ssub = sadd - {1'b0, m_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_tvalid && !rv_ff) begin
               if (in_mode == MODE_RES6 || in_mode == MODE_RES7 || in_m == '0 ||
                   (in_mode == MODE_DIV && in_b == '0) || in_m == WIDTH'(1))
                  state_in = ST_OUTPUT;
               else
                  state_in = ST_RED_A;
            end
         ST_RED_A: if (ustat.done) state_in = ST_RED_B;
         ST_RED_B: if (ustat.done) state_in = ST_DISPATCH;
         ST_DISPATCH:
            unique case (mode_ff)
               MODE_ADD, MODE_SUB: state_in = ST_OUTPUT;
               MODE_MUL: state_in = ST_MUL_RUN;
               MODE_POW: state_in = ST_POW_CHECK;
               MODE_INV, MODE_DIV: state_in = ST_INV_CHECK;
               default: state_in = ST_OUTPUT;
            endcase
         ST_MUL_RUN: if (ustat.done) state_in = ST_OUTPUT;
         ST_POW_CHECK: if (e_ff == '0) state_in = ST_OUTPUT;
            else state_in = ST_POW_SQR;
         ST_POW_SQR: if (ustat.done) state_in = ST_POW_CHECK;
         ST_INV_CHECK: if (r1_ff == '0) state_in = ST_INV_DONE;
            else state_in = ST_INV_DIV;
         ST_INV_DIV: if (ustat.done) state_in = ST_INV_MUL;
         ST_INV_MUL: if (ustat.done) state_in = ST_INV_SUB;
         ST_INV_SUB: state_in = ST_INV_CHECK;
         ST_INV_DONE:
            if (r0_ff != WIDTH'(1) || mode_ff == MODE_INV) state_in = ST_OUTPUT;
            else state_in = ST_DIV_MUL;
         ST_DIV_MUL: if (ustat.done) state_in = ST_OUTPUT;
         ST_OUTPUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit control.
   always_comb begin
      a_in = a_ff; b_in = b_ff; e_in = e_ff; acc_in = acc_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff; q_in = q_ff;
      res_in = res_ff; st_in = st_ff; pow_sq_in = pow_sq_ff;
      rv_in = rv_ff && !rsp_tready;
      uctrl = '0; ux = '0; uy = '0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && !rv_ff) begin
            // Division by the modulus: dividend a, divisor m.
            uctrl.start = 1'b1;
            uctrl.is_div = 1'b1;
            uy = in_a;
            res_in = '0;
            st_in = STATUS_OK;
            if (!(in_mode == MODE_RES6 || in_mode == MODE_RES7) &&
                (in_m == '0 || (in_mode == MODE_DIV && in_b == '0)))
               st_in = STATUS_ZERO;
            a_in = in_a; b_in = in_b; e_in = in_b;
         end
         ST_RED_A: if (ustat.done) begin
            a_in = uacc;
            uctrl.start = 1'b1; uctrl.is_div = 1'b1; uy = b_ff;
         end
         ST_RED_B: if (ustat.done) b_in = uacc;
         ST_DISPATCH: begin
            acc_in = WIDTH'(1);
            r0_in = m_ff; r1_in = (mode_ff == MODE_INV) ? a_ff : b_ff;
            t0_in = '0; t1_in = WIDTH'(1);
            pow_sq_in = 1'b0;
            if (mode_ff == MODE_ADD)
               res_in = (sadd[WIDTH] || !ssub[WIDTH]) ? ssub[WIDTH-1:0]
                                                      : sadd[WIDTH-1:0];
            if (mode_ff == MODE_SUB)
               res_in = (a_ff >= b_ff) ? a_ff - b_ff : m_ff - (b_ff - a_ff);
            if (mode_ff == MODE_MUL) begin
               uctrl.start = 1'b1; ux = a_ff; uy = b_ff;
            end
         end
         ST_MUL_RUN: if (ustat.done) res_in = uacc;
         ST_POW_CHECK: begin
            res_in = acc_ff;
            if (e_ff != '0) begin
               // Multiply into the accumulator when the bit is set, else square.
               uctrl.start = 1'b1;
               pow_sq_in = !e_ff[0];
               ux = e_ff[0] ? acc_ff : a_ff;
               uy = a_ff;
            end
         end
         ST_POW_SQR: if (ustat.done) begin
            if (!pow_sq_ff) begin
               // The low exponent bit is used up; a square follows if bits remain.
               acc_in = uacc;
               e_in = {e_ff[WIDTH-1:1], 1'b0};
            end else begin
               a_in = uacc;
               e_in = e_ff >> 1;
            end
         end
         ST_INV_CHECK: if (r1_ff != '0) begin
            // Division r0 / r1 uses the unit with r1 as divisor.
            uctrl.start = 1'b1; uctrl.is_div = 1'b1; uy = r0_ff;
         end
         ST_INV_DIV: if (ustat.done) begin
            q_in = uquot;
            r0_in = r1_ff; r1_in = uacc;
            // The quotient is at most the modulus, and a multiplicand equal to
            // the modulus reduces to zero in the unit.
            uctrl.start = 1'b1; ux = uquot; uy = t1_ff;
         end
         ST_INV_MUL: if (ustat.done) q_in = uacc;
         ST_INV_SUB: begin
            t0_in = t1_ff;
            t1_in = (t0_ff >= q_ff) ? t0_ff - q_ff : m_ff - (q_ff - t0_ff);
         end
         ST_INV_DONE: begin
            if (r0_ff != WIDTH'(1)) st_in = STATUS_NOINV;
            else if (mode_ff == MODE_INV) res_in = t0_ff;
            else begin
               uctrl.start = 1'b1; ux = a_ff; uy = t0_ff;
            end
         end
         ST_DIV_MUL: if (ustat.done) res_in = uacc;
         ST_OUTPUT: rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      if (state_ff == ST_IDLE && req_tvalid && !rv_ff) begin
         mode_ff <= in_mode;
         m_ff <= in_m;
      end
      a_ff <= a_in; b_ff <= b_in; e_ff <= e_in; acc_ff <= acc_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      q_ff <= q_in; res_ff <= res_in; st_ff <= st_in; pow_sq_ff <= pow_sq_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'd0, st_ff, 64'(res_ff)};
endmodule

### bench/modular_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the modular arithmetic unit. It works out the
// expected response for every accepted request and compares each accepted
// response, in order, with the oldest expectation.
module modular_arithmetic_unit_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // mode[2:0], operand_a[66:3], operand_b[130:67], modulus[194:131], zero pad
   input  logic [199:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result[63:0], status[65:64], zero pad
   input  logic [71:0]  rsp_tdata,
   output int           failures,
   output int           awaited
);
   import mau_pkg::*;

   typedef struct packed {
      logic [63:0] result;
      logic [1:0]  status;
   } answer_type;

   answer_type answers_due[$];

   // Sum of two residues; the carry out of 64 bits forces a reduction.
   function automatic logic [63:0] residue_sum(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] m);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
   endfunction

   function automatic logic [63:0] residue_diff(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
      return (x >= y) ? x - y : m - (y - x);
   endfunction

   // Product by double-and-add, most significant multiplier bit first.
   function automatic logic [63:0] residue_product(logic [63:0] x, logic [63:0] y,
                                                   logic [63:0] m);
      logic [63:0] acc;
      acc = '0;
      for (int i = 63; i >= 0; i--) begin
         acc = residue_sum(acc, acc, m);
         if (y[i]) acc = residue_sum(acc, x, m);
      end
      return acc;
   endfunction

   // Square-and-multiply over the whole, unreduced exponent.
   function automatic logic [63:0] residue_power(logic [63:0] base, logic [63:0] e,
                                                 logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (e != 0) begin
         if (e[0]) acc = residue_product(acc, base, m);
         e = e >> 1;
         if (e != 0) base = residue_product(base, base, m);
      end
      return acc;
   endfunction

   // Extended Euclid; returns 0 when x and m are not coprime.
   function automatic bit residue_inverse(logic [63:0] x, logic [63:0] m,
                                          output logic [63:0] inv);
      logic [63:0] r0, r1, t0, t1, q, tmp;
      r0 = m;
      r1 = x;
      t0 = 0;
      t1 = 1;
      inv = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = r0 - q * r1;
         r0 = r1;
         r1 = tmp;
         tmp = residue_diff(t0, residue_product(q % m, t1, m), m);
         t0 = t1;
         t1 = tmp;
      end
      if (r0 != 1) return 0;
      inv = t0;
      return 1;
   endfunction

   function automatic answer_type modular_answer(logic [199:0] data);
      mode_type    mode;
      logic [63:0] a, b, m, ar, br, inv;
      answer_type  ans;
      mode = mode_type'(data[2:0]);
      a = data[66:3];
      b = data[130:67];
      m = data[194:131];
      ans = '{result: '0, status: STATUS_OK};
      if (mode == MODE_RES6 || mode == MODE_RES7) begin
         // Unused modes answer zero with a good status.
      end else if (m == 0) begin
         ans.status = STATUS_ZERO;
      end else if (mode == MODE_DIV && b == 0) begin
         ans.status = STATUS_ZERO;
      end else if (m != 1) begin
         ar = a % m;
         br = b % m;
         case (mode)
            MODE_ADD: ans.result = residue_sum(ar, br, m);
            MODE_SUB: ans.result = residue_diff(ar, br, m);
            MODE_MUL: ans.result = residue_product(ar, br, m);
            MODE_POW: ans.result = residue_power(ar, b, m);
            MODE_INV: begin
               if (residue_inverse(ar, m, inv)) ans.result = inv;
               else ans.status = STATUS_NOINV;
            end
            default: begin
               if (residue_inverse(br, m, inv)) ans.result = residue_product(ar, inv, m);
               else ans.status = STATUS_NOINV;
            end
         endcase
      end
      return ans;
   endfunction

   // Record each request transaction and check each response transaction.
   always @(posedge clock) begin
      answer_type due;
      int         errs;
      errs = 0;
      if (reset) begin
         failures <= 0;
         awaited <= 0;
      end else begin
         if (req_tvalid && req_tready) answers_due.push_back(modular_answer(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("response transaction with no request outstanding");
               errs = errs + 1;
            end else begin
               due = answers_due.pop_front();
               if (rsp_tdata[63:0] !== due.result) begin
                  $error("result: expected %h, actual %h", due.result, rsp_tdata[63:0]);
                  errs = errs + 1;
               end
               if (rsp_tdata[65:64] !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_tdata[65:64]);
                  errs = errs + 1;
               end
            end
         end
         failures <= failures + errs;
         awaited <= answers_due.size();
      end
   end

endmodule

### bench/modular_arithmetic_unit_test.sv
`timescale 1ns / 1ps
// Drives request transactions into the modular arithmetic unit with random
// gaps, stalls the response side at random and gives the verdict.
module modular_arithmetic_unit_test;
   import mau_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [199:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   int           failures;
   int           awaited;
   bit           quiet_phase;
   int           mode_count [8];
   int           request_total;

   modular_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   modular_arithmetic_unit_checker checker_unit (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .failures(failures), .awaited(awaited)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("FAIL modular_arithmetic_unit");
      $finish;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int idle_cycles();
      return quiet_phase ? 0 : $urandom_range(0, 4);
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(mode_type mode, logic [63:0] a, logic [63:0] b,
                               logic [63:0] m);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, m, b, a, mode};
      do @(posedge clock); while (!req_tready);
      mode_count[mode]++;
      request_total++;
   endtask

   // Random modulus: mostly full width or small, now and then zero or one.
   function automatic logic [63:0] random_modulus();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return 64'd1;
         2, 3, 4: return 64'($urandom_range(2, 1000));
         5: return '1;
         default: return random_word();
      endcase
   endfunction

   // Response side: random stalls before each response transaction.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [63:0] a, b, m;
      mode_type    mode;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      quiet_phase = 0;
      request_total = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: field extremes, each mode and the special cases.
      send_request(MODE_ADD, '1, '1, '1);
      send_request(MODE_ADD, '1, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFF1);
      send_request(MODE_ADD, 64'd12345, 64'd999, 64'd97);
      send_request(MODE_SUB, 64'd3, 64'd10, 64'd13);
      send_request(MODE_SUB, '0, '1, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(MODE_MUL, '1, '1, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(MODE_MUL, 64'hDEAD_BEEF_0123_4567, 64'h1234_5678_9ABC_DEF0, '1);
      send_request(MODE_POW, 64'd7, 64'd0, 64'd13);
      send_request(MODE_POW, 64'd3, 64'd200, 64'd1000);
      send_request(MODE_POW, 64'h0123_4567_89AB_CDEF, '1, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(MODE_INV, 64'd3, 64'd0, 64'd7);
      send_request(MODE_INV, 64'd6, '1, 64'd9);
      send_request(MODE_INV, 64'd0, 64'd0, 64'd1);
      send_request(MODE_INV, '1, 64'd0, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(MODE_DIV, 64'd10, 64'd3, 64'd17);
      send_request(MODE_DIV, 64'd10, 64'd0, 64'd17);
      send_request(MODE_DIV, 64'd10, 64'd4, 64'd8);
      send_request(MODE_DIV, 64'd5, 64'd17, 64'd17);
      send_request(MODE_ADD, 64'd5, 64'd6, 64'd0);
      send_request(MODE_POW, 64'd5, 64'd6, 64'd0);
      send_request(MODE_MUL, 64'd5, 64'd6, 64'd1);
      send_request(MODE_RES6, '1, '1, '1);
      send_request(MODE_RES7, 64'd1, 64'd2, 64'd0);

      // Random requests, with quiet stretches where neither side idles.
      for (int i = 0; i < 80; i++) begin
         if (i % 16 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
         mode = ($urandom_range(0, 19) == 0) ? mode_type'($urandom_range(6, 7))
                                             : mode_type'($urandom_range(0, 5));
         m = random_modulus();
         a = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 2000)) : random_word();
         b = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 2000)) : random_word();
         send_request(mode, a, b, m);
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding responses, then allow a short settling time.
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests: add %0d, sub %0d, mul %0d, pow %0d, inv %0d, div %0d,",
               request_total, mode_count[0], mode_count[1], mode_count[2],
               mode_count[3], mode_count[4], mode_count[5]);
      $display("unused modes %0d; %0d mismatches found.",
               mode_count[6] + mode_count[7], failures);
      if (failures == 0) begin
         $display("PASS modular_arithmetic_unit");
      end else begin
         $display("FAIL modular_arithmetic_unit");
      end
      $finish;
   end

endmodule
